// File: src/lgo_pkg.sv
// ----------------------------------------------------------------------------
// lgo_pkg
// Shared types and constants for the log-odds occupancy grid cell store.
// ----------------------------------------------------------------------------
package lgo_pkg;

  // grid geometry
  localparam int unsigned NUM_CELLS = 65536;
  localparam int unsigned CELL_AW   = $clog2(NUM_CELLS);
  localparam int unsigned LOGIT_W   = 16;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HIT_INC  = 2'd0,
    REG_MISS_INC = 2'd1,
    REG_FLOOR    = 2'd2,
    REG_CEILING  = 2'd3
  } reg_idx_t;

  // configuration reset values, Q7.8
  localparam logic [14:0]        HIT_INC_RST  = 15'd218;
  localparam logic signed [15:0] MISS_INC_RST = -16'sd102;
  localparam logic signed [15:0] FLOOR_RST    = -16'sd512;
  localparam logic [14:0]        CEILING_RST  = 15'd896;

  // saturation limits on the widened sum
  localparam logic signed [17:0] SUM_MAX = 18'sd32767;
  localparam logic signed [17:0] SUM_MIN = -18'sd32768;

  // sweep controller states
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } sweep_state_t;

  // one memory word: observed flag and logit
  typedef struct packed {
    logic                      seen;
    logic signed [LOGIT_W-1:0] logit;
  } cell_word_t;

endpackage

// File: src/lgo_if.sv
// ----------------------------------------------------------------------------
// lgo_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lgo_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] cell_index;
  logic        hit;

  modport source (output valid, output op, output cell_index, output hit, input ready);
  modport sink (input valid, input op, input cell_index, input hit, output ready);
endinterface

interface lgo_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_value;
  logic               cell_seen;

  modport source (output valid, output cell_value, output cell_seen, input ready);
  modport sink (input valid, input cell_value, input cell_seen, output ready);
endinterface

// File: src/log_odds_grid_cell_update.sv
// ----------------------------------------------------------------------------
// log_odds_grid_cell_update
// Occupancy grid of Q7.8 log-odds cells: update with clamp, read, clear.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  in_chan   | in        | valid/ready        | op, cell_index, hit
//  out_chan  | out       | valid/ready        | cell_value, cell_seen
//  cfg_*     | in        | apb, pready high   | four registers at 4*i
//
//  one item per cycle while the output does not stall; each result goes
//  through stage 1 (memory read), then modify/write back into the output
//  register, which drives out_chan.valid.
//  back-to-back updates of one cell are forwarded from the write-back stage.
//  after reset a sweep zeroes the memory one cell a cycle, all NUM_CELLS
//  (65536) cells, with in_chan.ready low; a clear item holds ready low until
//  it leaves stage 1, which a stalled output delays, and then the same sweep.
//  a stalled output holds the pipeline; cfg writes are taken at any time.
// ----------------------------------------------------------------------------
module log_odds_grid_cell_update (
  input  logic               clk,
  input  logic               rst_n,
  lgo_cmd_if.sink            in_chan,
  lgo_rsp_if.source          out_chan,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int unsigned AW = lgo_pkg::CELL_AW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(lgo_pkg::NUM_CELLS - 1);

  // configuration registers
  logic [14:0]        hit_inc_r;
  logic signed [15:0] miss_inc_r;
  logic signed [15:0] floor_r;
  logic [14:0]        ceiling_r;
  logic               cfg_wr;
  lgo_pkg::reg_idx_t  cfg_idx;

  // sweep control
  lgo_pkg::sweep_state_t state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                  sweep_wr;
  logic                  run_ok;

  // stage 1 (memory data returns)
  logic                  s1_valid_r;
  logic [1:0]            s1_op_r;
  logic [AW-1:0]         s1_addr_r;
  logic                  s1_hit_r;
  logic                  s1_range_r;
  logic                  s1_fwd_r;
  lgo_pkg::cell_word_t   s1_fwd_word_r;
  logic                  s1_adv;
  logic                  s1_wr;
  logic                  s1_is_clear;

  // output register
  logic                  out_valid_r;
  logic signed [15:0]    out_value_r;
  logic                  out_seen_r;

  // accept side
  logic                  in_acc;
  logic [AW-1:0]         in_addr;
  logic                  in_range;

  // memory ports
  logic                  mem_wr;
  logic [AW-1:0]         mem_wr_addr;
  lgo_pkg::cell_word_t   mem_wr_data;
  lgo_pkg::cell_word_t   rd_word;

  // update datapath
  lgo_pkg::cell_word_t   old_word;
  logic signed [17:0]    old_wide;
  logic signed [17:0]    sum_hit;
  logic signed [17:0]    sum_miss;
  logic signed [17:0]    ceil_wide;
  logic signed [17:0]    floor_wide;
  logic signed [17:0]    clamped;
  logic signed [15:0]    new_logit;
  logic signed [15:0]    res_value;
  logic                  res_seen;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_idx    = lgo_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_inc_r  <= lgo_pkg::HIT_INC_RST;
      miss_inc_r <= lgo_pkg::MISS_INC_RST;
      floor_r    <= lgo_pkg::FLOOR_RST;
      ceiling_r  <= lgo_pkg::CEILING_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lgo_pkg::REG_HIT_INC:  hit_inc_r  <= cfg_pwdata[14:0];
        lgo_pkg::REG_MISS_INC: miss_inc_r <= cfg_pwdata[15:0];
        lgo_pkg::REG_FLOOR:    floor_r    <= cfg_pwdata[15:0];
        lgo_pkg::REG_CEILING:  ceiling_r  <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      lgo_pkg::REG_HIT_INC:  cfg_prdata = {17'd0, hit_inc_r};
      lgo_pkg::REG_MISS_INC: cfg_prdata = {{16{miss_inc_r[15]}}, miss_inc_r};
      lgo_pkg::REG_FLOOR:    cfg_prdata = {{16{floor_r[15]}}, floor_r};
      lgo_pkg::REG_CEILING:  cfg_prdata = {17'd0, ceiling_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- sweep fsm
  assign s1_is_clear = s1_valid_r && (s1_op_r == lgo_pkg::OP_CLEAR);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lgo_pkg::ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = lgo_pkg::ST_RUN;
      end
      lgo_pkg::ST_RUN: begin
        if (s1_is_clear && s1_adv) state_nxt = lgo_pkg::ST_CLEAR;
      end
      default: state_nxt = lgo_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    sweep_wr     = 1'b0;
    run_ok       = 1'b0;
    clr_addr_nxt = '0;
    case (state_r)
      lgo_pkg::ST_CLEAR: begin
        sweep_wr     = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      lgo_pkg::ST_RUN: begin
        run_ok = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lgo_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // ---------------------------------------------------------------- accept
  assign s1_adv   = !out_valid_r || out_chan.ready;
  assign in_chan.ready = run_ok && (!s1_valid_r || (s1_adv && !s1_is_clear));
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign in_addr  = AW'(in_chan.cell_index);
  assign in_range = 32'(in_chan.cell_index) < lgo_pkg::NUM_CELLS;

  // stage 1 capture, with forward of the write landing this edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r       <= in_chan.op;
      s1_addr_r     <= in_addr;
      s1_hit_r      <= in_chan.hit;
      s1_range_r    <= in_range;
      s1_fwd_r      <= s1_wr && (s1_addr_r == in_addr);
      s1_fwd_word_r <= mem_wr_data;
    end
  end

  // ---------------------------------------------------------------- memory
  assign s1_wr       = s1_valid_r && s1_adv && s1_range_r &&
                       (s1_op_r == lgo_pkg::OP_UPDATE);
  assign mem_wr      = sweep_wr || s1_wr;
  assign mem_wr_addr = sweep_wr ? clr_addr_r : s1_addr_r;

  always_comb begin
    if (sweep_wr) begin
      mem_wr_data = '0;
    end else begin
      mem_wr_data.seen  = 1'b1;
      mem_wr_data.logit = new_logit;
    end
  end

  lgo_cell_ram u_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (rd_word)
  );

  // ---------------------------------------------------------------- update math
  assign old_word   = s1_fwd_r ? s1_fwd_word_r : rd_word;
  assign old_wide   = 18'(old_word.logit);
  assign ceil_wide  = $signed({3'b000, ceiling_r});
  assign floor_wide = 18'(floor_r);
  assign sum_hit    = old_wide + $signed({3'b000, hit_inc_r});
  assign sum_miss   = old_wide + 18'(miss_inc_r);

  // clamp against the bound, then saturate to 16 bits
  always_comb begin
    if (s1_hit_r) begin
      clamped = (sum_hit < ceil_wide) ? sum_hit : ceil_wide;
    end else begin
      clamped = (sum_miss > floor_wide) ? sum_miss : floor_wide;
    end
    if (clamped > lgo_pkg::SUM_MAX) begin
      new_logit = lgo_pkg::SUM_MAX[15:0];
    end else if (clamped < lgo_pkg::SUM_MIN) begin
      new_logit = lgo_pkg::SUM_MIN[15:0];
    end else begin
      new_logit = clamped[15:0];
    end
  end

  // result selection
  always_comb begin
    res_value = '0;
    res_seen  = 1'b0;
    case (s1_op_r)
      lgo_pkg::OP_UPDATE: begin
        if (s1_range_r) begin
          res_value = new_logit;
          res_seen  = 1'b1;
        end
      end
      lgo_pkg::OP_READ: begin
        if (s1_range_r && old_word.seen) begin
          res_value = old_word.logit;
          res_seen  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_value_r <= res_value;
      out_seen_r  <= res_seen;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.cell_value = out_value_r;
  assign out_chan.cell_seen  = out_seen_r;

endmodule

// File: src/lgo_cell_ram.sv
// ----------------------------------------------------------------------------
// lgo_cell_ram
// Single-port-write, single-port-read cell memory with registered read data.
// ----------------------------------------------------------------------------
module lgo_cell_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [lgo_pkg::CELL_AW-1:0]  wr_addr,
  input  lgo_pkg::cell_word_t          wr_data,
  input  logic                         rd_en,
  input  logic [lgo_pkg::CELL_AW-1:0]  rd_addr,
  output lgo_pkg::cell_word_t          rd_data
);

  lgo_pkg::cell_word_t mem [lgo_pkg::NUM_CELLS];
  lgo_pkg::cell_word_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the log-odds grid cell store. A short table of
// directed items covers reset contents, both clamps, the unused op code and
// the clear. Random items then run under several register settings, the
// extremes among them. A behavioral copy of the grid predicts each result that
// the table does not give, and every result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import lgo_pkg::*;

  localparam int unsigned RUN_LIMIT         = 2_000_000;
  localparam int unsigned HOLD_CYCLES       = 300;
  localparam int unsigned HOLD_AT_A         = 180;
  localparam int unsigned HOLD_AT_B         = 900;
  localparam int unsigned NUM_SETTINGS      = 5;
  localparam int unsigned ITEMS_PER_SETTING = 295;
  localparam int unsigned POOL_SIZE         = 8;
  localparam int unsigned MAX_REPORTS       = 10;
  localparam int unsigned SETTLE_CYCLES     = 8;
  localparam logic [1:0]  OP_UNUSED         = 2'd3;
  localparam int          LOGIT_MAX         = 32767;
  localparam int          LOGIT_MIN         = -32768;

  typedef struct {
    logic signed [15:0] value;
    logic               seen;
  } cell_result_t;

  typedef struct {
    logic [1:0]         op;
    logic [15:0]        idx;
    logic               hit;
    bit                 typed;
    logic signed [15:0] value;
    logic               seen;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lgo_cmd_if cmd_ch();
  lgo_rsp_if rsp_ch();

  log_odds_grid_cell_update dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (cmd_ch),
    .out_chan    (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the grid and its registers
  logic signed [15:0] grid_logit [int unsigned];
  bit                 grid_seen  [int unsigned];
  logic [14:0]        hit_inc_q;
  logic signed [15:0] miss_inc_q;
  logic signed [15:0] floor_q;
  logic [14:0]        ceil_q;

  cell_result_t cell_results_due [$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_taken  = 0;
  bit           send_burst     = 1'b0;
  bit           take_burst     = 1'b0;

  // directed items: after reset, ceiling and floor clamps, unused op, clear
  step_row_t dir_rows [25] = '{
    '{OP_READ,   16'h0000, 1'b0, 1'b1, 16'sd0,    1'b0},
    '{OP_READ,   16'hffff, 1'b0, 1'b1, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'h0000, 1'b1, 1'b1, 16'sd218,  1'b1},
    '{OP_UPDATE, 16'h0000, 1'b1, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'h0000, 1'b1, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'h0000, 1'b1, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'h0000, 1'b1, 1'b1, 16'sd896,  1'b1},
    '{OP_READ,   16'h0000, 1'b0, 1'b1, 16'sd896,  1'b1},
    '{OP_UPDATE, 16'hffff, 1'b0, 1'b1, -16'sd102, 1'b1},
    '{OP_UPDATE, 16'hffff, 1'b0, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'hffff, 1'b0, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'hffff, 1'b0, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'hffff, 1'b0, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'hffff, 1'b0, 1'b1, -16'sd512, 1'b1},
    '{OP_READ,   16'hffff, 1'b0, 1'b1, -16'sd512, 1'b1},
    '{OP_UNUSED, 16'h0000, 1'b1, 1'b1, 16'sd0,    1'b0},
    '{OP_READ,   16'h0000, 1'b0, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'h0000, 1'b0, 1'b0, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'hffff, 1'b1, 1'b0, 16'sd0,    1'b0},
    '{OP_CLEAR,  16'h0000, 1'b0, 1'b1, 16'sd0,    1'b0},
    '{OP_READ,   16'h0000, 1'b0, 1'b1, 16'sd0,    1'b0},
    '{OP_READ,   16'hffff, 1'b0, 1'b1, 16'sd0,    1'b0},
    '{OP_UPDATE, 16'h5555, 1'b1, 1'b1, 16'sd218,  1'b1},
    '{OP_UNUSED, 16'haaaa, 1'b0, 1'b1, 16'sd0,    1'b0},
    '{OP_READ,   16'haaaa, 1'b0, 1'b1, 16'sd0,    1'b0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("** log_odds_grid_cell_update: FAILED **");
    $finish;
  end

  // advance the shadow grid by one item and give its result
  function automatic void apply_cell_op(input logic [1:0] op, input logic [15:0] idx,
                                        input logic hit, output cell_result_t res);
    int prior;
    int sum;
    int nxt;
    res.value = '0;
    res.seen  = 1'b0;
    case (op)
      OP_CLEAR: begin
        grid_logit.delete();
        grid_seen.delete();
      end
      OP_UPDATE: begin
        prior = 0;
        if (grid_logit.exists(idx)) prior = int'(grid_logit[idx]);
        // hit only clamps at the ceiling, free only at the floor
        if (hit) begin
          sum = prior + int'(hit_inc_q);
          nxt = (sum < int'(ceil_q)) ? sum : int'(ceil_q);
        end else begin
          sum = prior + int'(miss_inc_q);
          nxt = (sum > int'(floor_q)) ? sum : int'(floor_q);
        end
        if (nxt > LOGIT_MAX) nxt = LOGIT_MAX;
        else if (nxt < LOGIT_MIN) nxt = LOGIT_MIN;
        grid_logit[idx] = nxt[15:0];
        grid_seen[idx]  = 1'b1;
        res.value       = nxt[15:0];
        res.seen        = 1'b1;
      end
      OP_READ: begin
        if (grid_seen.exists(idx)) begin
          res.value = grid_logit[idx];
          res.seen  = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // offer one item after a random gap, predict once it is taken
  task automatic send_item(input logic [1:0] op, input logic [15:0] idx, input logic hit,
                           input bit typed, input logic signed [15:0] value,
                           input logic seen);
    int unsigned  gap;
    cell_result_t res;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.op         <= op;
    cmd_ch.cell_index <= idx;
    cmd_ch.hit        <= hit;
    do @(posedge clk); while (!cmd_ch.ready);
    apply_cell_op(op, idx, hit, res);
    if (typed) begin
      res.value = value;
      res.seen  = seen;
    end
    cell_results_due.insert(cell_results_due.size(), res);
  endtask

  // apb write: setup then access
  task automatic write_reg(input reg_idx_t which, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {which, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (which)
      REG_HIT_INC:  hit_inc_q  = data[14:0];
      REG_MISS_INC: miss_inc_q = data[15:0];
      REG_FLOOR:    floor_q    = data[15:0];
      REG_CEILING:  ceil_q     = data[14:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold until every expected result has come back
  task automatic wait_drained();
    while (cell_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, two long holds
  initial begin
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results_taken == HOLD_AT_A || results_taken == HOLD_AT_B) stall = HOLD_CYCLES;
      else stall = take_burst ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      results_taken++;
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin
    cell_result_t due;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (cell_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: value %0d seen %0b", rsp_ch.cell_value,
                   rsp_ch.cell_seen);
      end else begin
        due = cell_results_due.pop_front();
        if (rsp_ch.cell_value !== due.value || rsp_ch.cell_seen !== due.seen) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected value %0d seen %0b, got value %0d seen %0b",
                     due.value, due.seen, rsp_ch.cell_value, rsp_ch.cell_seen);
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned        s;
    int unsigned        n;
    int unsigned        clear_at;
    int unsigned        hit_bias;
    int unsigned        pick;
    logic [15:0]        pool [POOL_SIZE];
    logic [1:0]         op_v;
    logic [15:0]        idx_v;
    logic               hit_v;
    logic [14:0]        hit_w;
    logic signed [15:0] miss_w;
    logic signed [15:0] floor_w;
    logic [14:0]        ceil_w;

    rst_n             <= 1'b0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.op         <= OP_UPDATE;
    cmd_ch.cell_index <= '0;
    cmd_ch.hit        <= 1'b0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    hit_inc_q  = HIT_INC_RST;
    miss_inc_q = MISS_INC_RST;
    floor_q    = FLOOR_RST;
    ceil_q     = CEILING_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table under reset settings
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].hit, dir_rows[i].typed,
                dir_rows[i].value, dir_rows[i].seen);
    cmd_ch.valid <= 1'b0;
    wait_drained();

    // random items under each register setting
    for (s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: begin  // widest steps and bounds
          hit_w = 15'h7fff; miss_w = 16'sh8000; floor_w = 16'sh8000; ceil_w = 15'h7fff;
        end
        1: begin  // smallest steps and tightest bounds
          hit_w = 15'd1; miss_w = -16'sd1; floor_w = -16'sd1; ceil_w = 15'd1;
        end
        2: begin  // out of range: zero hit, positive miss, inverted bounds
          hit_w = 15'd0; miss_w = 16'sd300; floor_w = 16'sh7fff; ceil_w = 15'd0;
        end
        3: begin  // both sums can run past the signed range
          hit_w = 15'h7fff; miss_w = 16'sh7fff; floor_w = 16'sh8000; ceil_w = 15'h7fff;
        end
        default: begin
          hit_w   = 15'($urandom_range(1, 2000));
          miss_w  = 16'(-int'($urandom_range(1, 2000)));
          floor_w = 16'(-int'($urandom_range(256, 8192)));
          ceil_w  = 15'($urandom_range(256, 8192));
        end
      endcase
      write_reg(REG_HIT_INC,  {17'd0, hit_w});
      write_reg(REG_MISS_INC, {{16{miss_w[15]}}, miss_w});
      write_reg(REG_FLOOR,    {{16{floor_w[15]}}, floor_w});
      write_reg(REG_CEILING,  {17'd0, ceil_w});

      // a few hot cells so that updates pile up into the clamps
      pool[0] = 16'h0000;
      pool[1] = 16'hffff;
      for (int k = 2; k < POOL_SIZE; k++) pool[k] = 16'($urandom_range(0, 65535));
      clear_at = $urandom_range(50, 250);
      hit_bias = $urandom_range(20, 80);

      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        pick = $urandom_range(0, 99);
        if (n == clear_at) op_v = OP_CLEAR;
        else if (pick < 62) op_v = OP_UPDATE;
        else if (pick < 92) op_v = OP_READ;
        else op_v = OP_UNUSED;
        if ($urandom_range(0, 99) < 80) idx_v = pool[$urandom_range(0, POOL_SIZE - 1)];
        else idx_v = 16'($urandom_range(0, 65535));
        hit_v = ($urandom_range(0, 99) < hit_bias);
        send_item(op_v, idx_v, hit_v, 1'b0, 16'sd0, 1'b0);
      end
      cmd_ch.valid <= 1'b0;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("** log_odds_grid_cell_update: PASSED **");
    end else begin
      $display("** log_odds_grid_cell_update: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
src/lgo_pkg.sv
src/lgo_if.sv
src/lgo_cell_ram.sv
src/log_odds_grid_cell_update.sv
tb/tb_top.sv
